// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbd_pkg;

   localparam int LINE_LIMIT_DEF = 64;
   localparam int SIZE_WIDTH_DEF = 32;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF_HEX = 8'h66;  // 'f'
   localparam logic [7:0] HEX_TEN    = 8'd10;

   typedef enum logic [1:0] {
      PH_SIZE,
      PH_DATA,
      PH_SKIP,
      PH_DONE
   } hcbd_phase_type;

   // one result word, packed framing_error, decode_done, out_valid, out_byte
   typedef struct packed {
      logic       framing_error;
      logic       decode_done;
      logic       out_valid;
      logic [7:0] out_byte;
   } hcbd_result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hcbd_hex_type;

   function automatic hcbd_hex_type hex_decode(input logic [7:0] c);
      hcbd_hex_type r;
      logic [7:0]   d;
      r = '0;
      d = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d     = c - CHAR_0;
         r.ok  = 1'b1;
         r.val = d[3:0];
      end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
         d     = c - CHAR_LA + HEX_TEN;
         r.ok  = 1'b1;
         r.val = d[3:0];
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d     = c - CHAR_UA + HEX_TEN;
         r.ok  = 1'b1;
         r.val = d[3:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/hcbd_decoder.sv =====
// ----------------------------------------------------------------------------
// hcbd_decoder
// Chunk framing state and per-byte decode; state advances on step_en.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbd_decoder #(
   parameter int LINE_LIMIT = hcbd_pkg::LINE_LIMIT_DEF,
   parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  logic                      chunked_mode,
   input  logic [7:0]                data_byte,
   input  logic                      body_start,
   output hcbd_pkg::hcbd_result_type result
);
   import hcbd_pkg::*;

   localparam int LCW = $clog2(LINE_LIMIT);

   localparam logic [LCW:0] LIMIT_W = LCW'(0) + (LCW+1)'(LINE_LIMIT);
   localparam logic [LCW:0] ONE_W   = (LCW+1)'(1);

   hcbd_phase_type        phase_ff, phase_in, phase_c;
   logic [SIZE_WIDTH-1:0] bytes_left_ff, bytes_left_in, bytes_left_c;
   logic [SIZE_WIDTH-1:0] size_accum_ff, size_accum_in, size_accum_c;
   logic                  digit_seen_ff, digit_seen_in, digit_seen_c;
   logic                  size_stopped_ff, size_stopped_in, size_stopped_c;
   logic [LCW-1:0]        line_count_ff, line_count_in, line_count_c;
   logic                  pending_cr_ff, pending_cr_in, pending_cr_c;
   logic                  error_seen_ff, error_seen_in, error_seen_c;

   hcbd_hex_type          hex;
   logic                  err_after_cr;
   logic                  is_stop;

   // body_start clears the decoder before the byte is looked at
   always_comb begin
      if (body_start) begin
         phase_c        = PH_SIZE;
         bytes_left_c   = '0;
         size_accum_c   = '0;
         digit_seen_c   = 1'b0;
         size_stopped_c = 1'b0;
         line_count_c   = '0;
         pending_cr_c   = 1'b0;
         error_seen_c   = 1'b0;
      end else begin
         phase_c        = phase_ff;
         bytes_left_c   = bytes_left_ff;
         size_accum_c   = size_accum_ff;
         digit_seen_c   = digit_seen_ff;
         size_stopped_c = size_stopped_ff;
         line_count_c   = line_count_ff;
         pending_cr_c   = pending_cr_ff;
         error_seen_c   = error_seen_ff;
      end
   end

   assign hex          = hex_decode(data_byte);
   assign err_after_cr = error_seen_c | (pending_cr_c & ~size_stopped_c);
   assign is_stop      = (data_byte == CHAR_SEMI) || (data_byte == CHAR_SPACE) ||
                         (data_byte == CHAR_TAB);

   // next state
   always_comb begin
      phase_in        = phase_c;
      bytes_left_in   = bytes_left_c;
      size_accum_in   = size_accum_c;
      digit_seen_in   = digit_seen_c;
      size_stopped_in = size_stopped_c;
      line_count_in   = line_count_c;
      pending_cr_in   = pending_cr_c;
      error_seen_in   = error_seen_c;
      if (chunked_mode) begin
         case (phase_c)
            PH_SIZE: begin
               if (data_byte == CHAR_LF) begin
                  if (error_seen_c || !digit_seen_c) begin
                     error_seen_in = 1'b1;
                     phase_in      = PH_DONE;
                  end else if (size_accum_c == '0) begin
                     phase_in = PH_DONE;
                  end else begin
                     bytes_left_in = size_accum_c;
                     phase_in      = PH_DATA;
                  end
                  size_accum_in   = '0;
                  digit_seen_in   = 1'b0;
                  size_stopped_in = 1'b0;
                  line_count_in   = '0;
                  pending_cr_in   = 1'b0;
               end else if (({1'b0, line_count_c} + ONE_W) < LIMIT_W) begin
                  line_count_in = line_count_c + LCW'(1);
                  pending_cr_in = 1'b0;
                  error_seen_in = err_after_cr;
                  if (!size_stopped_c && !err_after_cr) begin
                     if (is_stop) begin
                        size_stopped_in = 1'b1;
                     end else if (data_byte == CHAR_CR) begin
                        pending_cr_in = 1'b1;
                     end else if (!hex.ok) begin
                        error_seen_in = 1'b1;
                     end else if (size_accum_c[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                        error_seen_in = 1'b1;  // next digit would overflow
                     end else begin
                        size_accum_in = {size_accum_c[SIZE_WIDTH-5:0], hex.val};
                        digit_seen_in = 1'b1;
                     end
                  end
               end
            end
            PH_DATA: begin
               bytes_left_in = bytes_left_c - SIZE_WIDTH'(1);
               if (bytes_left_c == SIZE_WIDTH'(1)) begin
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (data_byte == CHAR_LF) begin
                  phase_in = PH_SIZE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result word
   always_comb begin
      result = '0;
      if (!chunked_mode) begin
         result.out_valid = 1'b1;
         result.out_byte  = data_byte;
      end else begin
         if (phase_c == PH_DATA) begin
            result.out_valid = 1'b1;
            result.out_byte  = data_byte;
         end
         result.decode_done   = (phase_in == PH_DONE);
         result.framing_error = (phase_in == PH_DONE) && error_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SIZE;
         bytes_left_ff   <= '0;
         size_accum_ff   <= '0;
         digit_seen_ff   <= 1'b0;
         size_stopped_ff <= 1'b0;
         line_count_ff   <= '0;
         pending_cr_ff   <= 1'b0;
         error_seen_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         size_accum_ff   <= size_accum_in;
         digit_seen_ff   <= digit_seen_in;
         size_stopped_ff <= size_stopped_in;
         line_count_ff   <= line_count_in;
         pending_cr_ff   <= pending_cr_in;
         error_seen_ff   <= error_seen_in;
      end
   end

endmodule

// ===== hw/rtl/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 body decoder: takes one body byte per word on req_, gives one
// result word per byte on rsp_. With csr_wdata written as 1 it strips chunked
// framing (hex size line up to LF, extensions after ';', space or tab
// ignored, only the first LINE_LIMIT-1 line characters counted), forwards the
// chunk data with out_valid set and reports decode_done / framing_error once
// the zero chunk or a bad or overflowing size line ends the body; written as
// 0 it forwards every byte. req_tuser set on a word restarts the decoder for
// a new body. Rate: one word per cycle sustained while rsp_ does not stall;
// an input register feeds the combinational decode step, which loads the
// result register. Either side may stall; a full input register holds one
// word while the result waits. Write csr_ only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module http_chunked_body_decoder #(
   parameter int LINE_LIMIT = hcbd_pkg::LINE_LIMIT_DEF,  // 4 .. 256
   parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF   // 8 .. 64
) (
   input  logic       clock,
   input  logic       reset,
   // config
   input  logic       csr_we,
   input  logic       csr_wdata,      // chunked_mode
   // input words
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,      // [7:0] data_byte
   input  logic       req_tuser,      // [0] body_start
   // result words
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,      // [7:0] out_byte
   output logic [2:0] rsp_tuser       // [0] out_valid, [1] decode_done,
                                      // [2] framing_error
);
   import hcbd_pkg::*;

   logic            mode_ff;

   // input register
   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_start_ff;

   // result register
   logic            out_valid_ff;
   hcbd_result_type out_res_ff;

   hcbd_result_type step_res;
   logic            advance;   // result register free to load this cycle
   logic            step_en;   // decode the held byte this cycle

   assign advance    = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   // framing state lives here; it steps once per decoded byte
   hcbd_decoder #(
      .LINE_LIMIT (LINE_LIMIT),
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .chunked_mode (mode_ff),
      .data_byte    (in_byte_ff),
      .body_start   (in_start_ff),
      .result       (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff.out_byte;
   assign rsp_tuser  = {out_res_ff.framing_error, out_res_ff.decode_done,
                        out_res_ff.out_valid};

   // an error is only ever reported together with done
   `ASSERT_ALWAYS(a_err_implies_done, clock, reset,
      !(rsp_tvalid && rsp_tuser[2] && !rsp_tuser[1]))
   // a payload byte never comes out once decoding has ended
   `ASSERT_ALWAYS(a_payload_not_done, clock, reset,
      !(rsp_tvalid && rsp_tuser[0] && rsp_tuser[1]))
   // non-payload words carry a zero byte
   `ASSERT_ALWAYS(a_zero_fill, clock, reset,
      !(rsp_tvalid && !rsp_tuser[0] && (rsp_tdata != 8'd0)))
   // both registers full and output stalled: no room for another word
   `ASSERT_ALWAYS(a_full_backpressure, clock, reset,
      !(in_valid_ff && rsp_tvalid && !rsp_tready && req_tready))
   // a held byte moves into a free result register on the next edge
   `ASSERT_NEXT(a_step_loads, clock, reset, step_en, rsp_tvalid)

endmodule
